// ----- design/ptt_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the timer table.
`timescale 1ns / 1ps

package ptt_pkg;

    // Table geometry and time format
    localparam int SLOTS         = 8;
    localparam int MAX_FIRES     = 7;
    localparam int TIME_BITS     = 24;
    localparam int SLOT_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FIRE_W        = $clog2(MAX_FIRES + 1);

    // Field widths of the ports
    localparam int OP_W          = 2;
    localparam int HANDLE_W      = 16;
    localparam int IN_TIME_W     = 24;
    localparam int PAYLOAD_W     = 32;
    localparam int DELTA_W       = 16;
    localparam int KIND_W        = 3;

    // Clamp arithmetic runs at the wider of input and stored time width
    localparam int CLAMP_W       = (TIME_BITS > IN_TIME_W) ? TIME_BITS : IN_TIME_W;
    localparam logic [CLAMP_W-1:0] MIN_TIME = CLAMP_W'(50);
    localparam logic [CLAMP_W-1:0] TIME_MAX = CLAMP_W'((64'd1 << TIME_BITS) - 64'd1);

    // Opcodes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] K_ADDED    = 3'd0;
    localparam logic [KIND_W-1:0] K_FULL     = 3'd1;
    localparam logic [KIND_W-1:0] K_REMOVED  = 3'd2;
    localparam logic [KIND_W-1:0] K_NOTFOUND = 3'd3;
    localparam logic [KIND_W-1:0] K_FIRED    = 3'd4;
    localparam logic [KIND_W-1:0] K_TICKDONE = 3'd5;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;    // latch a new item
        logic add;        // run an add
        logic remove;     // run a remove
        logic visit;      // age the current slot
        logic fire;       // emit one fire of the current slot
        logic slot_end;   // retire expired slot, step to next slot
        logic tick_done;  // emit closing tick result
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic slot_live;  // current slot holds a timer
        logic can_fire;   // current slot may fire once more
        logic slot_last;  // current slot is the highest one
    } t_stat;

    // Raise to the minimum, limit to the stored range
    function automatic logic [TIME_BITS-1:0] clamp_time(input logic [IN_TIME_W-1:0] v);
        logic [CLAMP_W-1:0] w;
        w = CLAMP_W'(v);
        if (w < MIN_TIME) begin
            w = MIN_TIME;
        end
        if (w > TIME_MAX) begin
            w = TIME_MAX;
        end
        return w[TIME_BITS-1:0];
    endfunction

endpackage

// ----- design/periodic_timer_table.sv -----
// Periodic timer table: eight slots of interval/lifetime timers with handles.
// Add and remove give their one registered result after the execute state. A tick visits
// each slot in turn; a live slot is aged, fires while it may and is retired when spent;
// tick done closes the walk. busy holds off start until the item's last result is out.
// Results appear one per cycle under o_strobe; the receiver cannot stall.
// Reset (synchronous, active low) empties every slot and sets the handle counter to zero.
`timescale 1ns / 1ps

module periodic_timer_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ptt_pkg::OP_W-1:0]          i_opcode,
    input  logic [ptt_pkg::HANDLE_W-1:0]      i_handle,
    input  logic [ptt_pkg::IN_TIME_W-1:0]     i_interval_ms,
    input  logic [ptt_pkg::IN_TIME_W-1:0]     i_duration_ms,
    input  logic [ptt_pkg::PAYLOAD_W-1:0]     i_payload,
    input  logic [ptt_pkg::DELTA_W-1:0]       i_delta_ms,
    output logic                              o_strobe,
    output logic [ptt_pkg::KIND_W-1:0]        o_kind,
    output logic [ptt_pkg::HANDLE_W-1:0]      o_out_handle,
    output logic [ptt_pkg::PAYLOAD_W-1:0]     o_out_payload,
    output logic                              o_last
);
    import ptt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    ptt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // Slot table and arithmetic
    ptt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_handle      (i_handle),
        .i_interval_ms (i_interval_ms),
        .i_duration_ms (i_duration_ms),
        .i_payload     (i_payload),
        .i_delta_ms    (i_delta_ms),
        .o_stat        (stat),
        .o_strobe      (o_strobe),
        .o_kind        (o_kind),
        .o_out_handle  (o_out_handle),
        .o_out_payload (o_out_payload),
        .o_last        (o_last)
    );

endmodule

// ----- design/ptt_ctrl.sv -----
// Controller state machine: sequences add, remove and the slot-by-slot tick walk.
`timescale 1ns / 1ps

module ptt_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic [ptt_pkg::OP_W-1:0] i_opcode,
    input  ptt_pkg::t_stat        i_stat,
    output ptt_pkg::t_cmd         o_cmd,
    output logic                  busy
);
    import ptt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_VISIT,
        S_FIRE,
        S_DONE
    } t_state;

    t_state          r_state, n_state;
    logic            r_is_add, n_is_add;
    logic            accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        n_is_add = r_is_add;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_is_add      = (i_opcode == OP_ADD);
                    case (i_opcode)
                        OP_ADD, OP_REMOVE: n_state = S_EXEC;
                        OP_TICK:           n_state = S_VISIT;
                        default:           n_state = S_IDLE;
                    endcase
                end
            end
            S_EXEC: begin
                o_cmd.add    = r_is_add;
                o_cmd.remove = !r_is_add;
                n_state      = S_IDLE;
            end
            S_VISIT: begin
                if (i_stat.slot_live) begin
                    o_cmd.visit = 1'b1;
                    n_state     = S_FIRE;
                end else begin
                    o_cmd.slot_end = 1'b1;
                    n_state        = i_stat.slot_last ? S_DONE : S_VISIT;
                end
            end
            S_FIRE: begin
                if (i_stat.can_fire) begin
                    o_cmd.fire = 1'b1;
                end else begin
                    o_cmd.slot_end = 1'b1;
                    n_state        = i_stat.slot_last ? S_DONE : S_VISIT;
                end
            end
            S_DONE: begin
                o_cmd.tick_done = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_is_add <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_is_add <= n_is_add;
        end
    end

endmodule

// ----- design/ptt_dp.sv -----
// Datapath: slot registers, item latch, ageing and fire arithmetic, result register.
`timescale 1ns / 1ps

module ptt_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ptt_pkg::t_cmd                     i_cmd,
    input  logic [ptt_pkg::HANDLE_W-1:0]      i_handle,
    input  logic [ptt_pkg::IN_TIME_W-1:0]     i_interval_ms,
    input  logic [ptt_pkg::IN_TIME_W-1:0]     i_duration_ms,
    input  logic [ptt_pkg::PAYLOAD_W-1:0]     i_payload,
    input  logic [ptt_pkg::DELTA_W-1:0]       i_delta_ms,
    output ptt_pkg::t_stat                    o_stat,
    output logic                              o_strobe,
    output logic [ptt_pkg::KIND_W-1:0]        o_kind,
    output logic [ptt_pkg::HANDLE_W-1:0]      o_out_handle,
    output logic [ptt_pkg::PAYLOAD_W-1:0]     o_out_payload,
    output logic                              o_last
);
    import ptt_pkg::*;

    // Slot table
    logic [SLOTS-1:0]          r_valid;
    logic [HANDLE_W-1:0]       r_slot_handle   [SLOTS];
    logic [PAYLOAD_W-1:0]      r_slot_payload  [SLOTS];
    logic [TIME_BITS-1:0]      r_slot_interval [SLOTS];
    logic [TIME_BITS-1:0]      r_slot_left     [SLOTS];
    logic [TIME_BITS-1:0]      r_slot_accum    [SLOTS];
    logic [HANDLE_W-1:0]       r_next_id;

    // Latched item
    logic [HANDLE_W-1:0]       r_handle;
    logic [TIME_BITS-1:0]      r_interval;
    logic [TIME_BITS-1:0]      r_duration;
    logic [PAYLOAD_W-1:0]      r_payload;
    logic [DELTA_W-1:0]        r_delta;

    // Walk counters
    logic [SLOT_W-1:0]         r_idx;
    logic [FIRE_W-1:0]         r_fires;

    // Result register
    logic                      r_strobe;
    logic [KIND_W-1:0]         r_kind;
    logic [HANDLE_W-1:0]       r_out_handle;
    logic [PAYLOAD_W-1:0]      r_out_payload;
    logic                      r_last;

    // Lowest free slot and handle matches
    logic                      any_free;
    logic [SLOT_W-1:0]         free_idx;
    logic [SLOTS-1:0]          match;

    always_comb begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                any_free = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            match[i] = r_valid[i] && (r_slot_handle[i] == r_handle);
        end
    end

    // Ageing of the current slot
    logic [TIME_BITS-1:0]      cur_left, cur_accum, cur_int;
    logic [TIME_BITS-1:0]      delta_ext;
    logic [TIME_BITS-1:0]      aged_left, aged_accum;
    logic [TIME_BITS:0]        accum_sum;

    assign cur_left   = r_slot_left[r_idx];
    assign cur_accum  = r_slot_accum[r_idx];
    assign cur_int    = r_slot_interval[r_idx];
    assign delta_ext  = TIME_BITS'(r_delta);
    assign aged_left  = (cur_left > delta_ext) ? (cur_left - delta_ext) : '0;
    assign accum_sum  = {1'b0, cur_accum} + {1'b0, delta_ext};
    assign aged_accum = accum_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : accum_sum[TIME_BITS-1:0];

    // Status
    assign o_stat.slot_live = r_valid[r_idx];
    assign o_stat.slot_last = (r_idx == SLOT_W'(SLOTS - 1));
    assign o_stat.can_fire  = (r_fires < FIRE_W'(MAX_FIRES)) && (cur_left != '0)
                              && (cur_accum >= cur_int);

    // Table, latch and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_next_id <= '0;
            r_idx     <= '0;
            r_fires   <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_handle   <= i_handle;
                r_interval <= clamp_time(i_interval_ms);
                r_duration <= clamp_time(i_duration_ms);
                r_payload  <= i_payload;
                r_delta    <= i_delta_ms;
                r_idx      <= '0;
            end
            if (i_cmd.add && any_free) begin
                r_valid[free_idx]         <= 1'b1;
                r_slot_handle[free_idx]   <= r_next_id;
                r_slot_payload[free_idx]  <= r_payload;
                r_slot_interval[free_idx] <= r_interval;
                r_slot_left[free_idx]     <= r_duration;
                r_slot_accum[free_idx]    <= '0;
                r_next_id                 <= r_next_id + 1'b1;
            end
            if (i_cmd.remove) begin
                r_valid <= r_valid & ~match;
            end
            if (i_cmd.visit) begin
                r_slot_left[r_idx]  <= aged_left;
                r_slot_accum[r_idx] <= aged_accum;
                r_fires             <= '0;
            end
            if (i_cmd.fire) begin
                r_slot_accum[r_idx] <= cur_accum - cur_int;
                r_fires             <= r_fires + 1'b1;
            end
            if (i_cmd.slot_end) begin
                if (r_valid[r_idx] && (cur_left == '0)) begin
                    r_valid[r_idx] <= 1'b0;
                end
                if (!o_stat.slot_last) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    // Result register: one transfer per strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.add || i_cmd.remove || i_cmd.fire || i_cmd.tick_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            r_kind        <= any_free ? K_ADDED : K_FULL;
            r_out_handle  <= any_free ? r_next_id : '0;
            r_out_payload <= '0;
            r_last        <= 1'b1;
        end else if (i_cmd.remove) begin
            r_kind        <= (|match) ? K_REMOVED : K_NOTFOUND;
            r_out_handle  <= r_handle;
            r_out_payload <= '0;
            r_last        <= 1'b1;
        end else if (i_cmd.fire) begin
            r_kind        <= K_FIRED;
            r_out_handle  <= r_slot_handle[r_idx];
            r_out_payload <= r_slot_payload[r_idx];
            r_last        <= 1'b0;
        end else begin
            r_kind        <= K_TICKDONE;
            r_out_handle  <= '0;
            r_out_payload <= '0;
            r_last        <= 1'b1;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_kind        = r_kind;
    assign o_out_handle  = r_out_handle;
    assign o_out_payload = r_out_payload;
    assign o_last        = r_last;

endmodule
